// File: rtl/core/forth_token_literal_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// Each macro checks an implication on the rising clock edge and is
// switched off while the synchronous reset is high.
`ifndef FORTH_TOKEN_LITERAL_CLASSIFIER_DEFINES_SVH
`define FORTH_TOKEN_LITERAL_CLASSIFIER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FTLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FTLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/ftlc_pkg.sv
`timescale 1ns / 1ps

package ftlc_pkg;

   // Lexer phase of the word being scanned.
   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_MINUS = 3'd1,
      PH_ZERO  = 3'd2,
      PH_ZEROX = 3'd3,
      PH_DEC   = 3'd4,
      PH_HEX   = 3'd5,
      PH_OTHER = 3'd6
   } phase_type;

   // Kind of word reported with the result.
   typedef enum logic [1:0] {
      KIND_DEC   = 2'd0,
      KIND_HEX   = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   localparam int unsigned MAG_W = 33;
   localparam int unsigned ACC_W = 37;

   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   // Largest magnitudes for a positive and a negative value.
   localparam logic [ACC_W-1:0] POS_LIMIT = 37'h0_FFFF_FFFF;
   localparam logic [ACC_W-1:0] NEG_LIMIT = 37'h0_8000_0000;

   // Marker returned for a character that is not a hex digit.
   localparam logic [4:0] NOT_HEX = 5'd16;

   // Scan state carried from one character to the next.
   typedef struct packed {
      phase_type        phase;
      logic             is_negative;
      logic [MAG_W-1:0] magnitude;
      logic             overflowed;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_START,
      is_negative: 1'b0,
      magnitude:   '0,
      overflowed:  1'b0
   };

   // One result word.
   typedef struct packed {
      kind_type           word_kind;
      logic signed [31:0] literal_value;
      logic               range_error;
   } result_type;

   // Hex digit value 0 to 15, or NOT_HEX for any other code.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41 + 8'd10);
      end else begin
         v = NOT_HEX;
      end
      return v;
   endfunction

endpackage

// File: rtl/core/ftlc_channel_if.sv
`timescale 1ns / 1ps

// Character channel: one character word per handshake.
interface ftlc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// Result channel: one classification word per handshake.
interface ftlc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         word_kind;
   logic signed [31:0] literal_value;
   logic               range_error;

   modport source (output valid, output word_kind, output literal_value,
                   output range_error, input ready);
   modport sink   (input valid, input word_kind, input literal_value,
                   input range_error, output ready);
endinterface

// File: rtl/core/ftlc_step.sv
`timescale 1ns / 1ps

// Per-character update: phase transition, value accumulation and the
// result formed on the last character of a word.
module ftlc_step (
   input  ftlc_pkg::state_type  cur_state,
   input  logic [7:0]           char_code,
   input  logic                 last_char,
   output ftlc_pkg::state_type  next_state,
   output ftlc_pkg::result_type result
);

   logic [4:0]                     hv;
   logic                           is_zero;
   logic                           is_dec;
   logic                           is_hex;
   ftlc_pkg::phase_type            phase_n;
   logic                           neg_n;
   logic [3:0]                     digit;
   logic [ftlc_pkg::ACC_W-1:0]     mag_wide;
   logic [ftlc_pkg::ACC_W-1:0]     dec_next;
   logic [ftlc_pkg::ACC_W-1:0]     hex_next;
   logic [ftlc_pkg::ACC_W-1:0]     acc_next;
   logic [ftlc_pkg::ACC_W-1:0]     limit;
   logic                           do_acc;
   ftlc_pkg::state_type            upd;

   // Character classes.
   always_comb begin
      hv      = ftlc_pkg::hex_value(char_code);
      is_zero = (char_code == ftlc_pkg::CHAR_ZERO);
      is_dec  = (hv < 5'd10);
      is_hex  = (hv != ftlc_pkg::NOT_HEX);
   end

   // Phase transition; a leading minus marks the value negative.
   always_comb begin
      neg_n = cur_state.is_negative;
      unique case (cur_state.phase)
         ftlc_pkg::PH_START: begin
            priority if (char_code == ftlc_pkg::CHAR_MINUS) begin
               phase_n = ftlc_pkg::PH_MINUS;
               neg_n   = 1'b1;
            end else if (is_zero) begin
               phase_n = ftlc_pkg::PH_ZERO;
            end else if (is_dec) begin
               phase_n = ftlc_pkg::PH_DEC;
            end else begin
               phase_n = ftlc_pkg::PH_OTHER;
            end
         end
         ftlc_pkg::PH_MINUS: begin
            priority if (is_zero) begin
               phase_n = ftlc_pkg::PH_ZERO;
            end else if (is_dec) begin
               phase_n = ftlc_pkg::PH_DEC;
            end else begin
               phase_n = ftlc_pkg::PH_OTHER;
            end
         end
         ftlc_pkg::PH_ZERO: begin
            phase_n = (char_code == ftlc_pkg::CHAR_LOWER_X) ? ftlc_pkg::PH_ZEROX
                                                             : ftlc_pkg::PH_OTHER;
         end
         ftlc_pkg::PH_ZEROX, ftlc_pkg::PH_HEX: begin
            phase_n = is_hex ? ftlc_pkg::PH_HEX : ftlc_pkg::PH_OTHER;
         end
         ftlc_pkg::PH_DEC: begin
            phase_n = is_dec ? ftlc_pkg::PH_DEC : ftlc_pkg::PH_OTHER;
         end
         default: begin
            phase_n = ftlc_pkg::PH_OTHER;
         end
      endcase
   end

   // Multiply-accumulate by 10 or 16 with the range check; the magnitude
   // freezes once the sticky range flag is set.
   always_comb begin
      digit    = is_dec ? hv[3:0] : 4'd0;
      mag_wide = {4'b0, cur_state.magnitude};
      dec_next = (mag_wide << 3) + (mag_wide << 1) + {33'b0, digit};
      hex_next = {cur_state.magnitude, hv[3:0]};
      acc_next = (phase_n == ftlc_pkg::PH_HEX) ? hex_next : dec_next;
      limit    = neg_n ? ftlc_pkg::NEG_LIMIT : ftlc_pkg::POS_LIMIT;
      do_acc   = (phase_n == ftlc_pkg::PH_DEC) || (phase_n == ftlc_pkg::PH_ZERO) ||
                 (phase_n == ftlc_pkg::PH_HEX);

      upd.phase       = phase_n;
      upd.is_negative = neg_n;
      upd.magnitude   = cur_state.magnitude;
      upd.overflowed  = cur_state.overflowed;
      if (do_acc && !cur_state.overflowed) begin
         if (acc_next > limit) begin
            upd.overflowed = 1'b1;
         end else begin
            upd.magnitude = acc_next[ftlc_pkg::MAG_W-1:0];
         end
      end
   end

   // Result of the word; the scan state restarts after the last character.
   always_comb begin
      result.literal_value = '0;
      result.range_error   = 1'b0;
      if (phase_n == ftlc_pkg::PH_DEC || phase_n == ftlc_pkg::PH_ZERO) begin
         result.word_kind = ftlc_pkg::KIND_DEC;
      end else if (phase_n == ftlc_pkg::PH_HEX) begin
         result.word_kind = ftlc_pkg::KIND_HEX;
      end else begin
         result.word_kind = ftlc_pkg::KIND_OTHER;
      end
      if (result.word_kind != ftlc_pkg::KIND_OTHER) begin
         if (upd.overflowed) begin
            result.range_error = 1'b1;
         end else if (upd.is_negative) begin
            result.literal_value = 32'sd0 - $signed(upd.magnitude[31:0]);
         end else begin
            result.literal_value = $signed(upd.magnitude[31:0]);
         end
      end
      next_state = last_char ? ftlc_pkg::STATE_RESET : upd;
   end

endmodule

// File: rtl/core/forth_token_literal_classifier.sv
`timescale 1ns / 1ps
// Numeric literal classifier for space-delimited words.
// Characters arrive on req_ch, one character per handshake, with last_char set
// on the final character of a word. For each word one result leaves on
// rsp_ch: word_kind (decimal, hex or other), the 32-bit value and a range
// flag. Characters that are not last produce no result.
// Path: a character is held in an input register and is scanned on its way
// out of it; the result of a word is registered in the output register when
// its last character leaves the input register. Throughput: one character
// per cycle, unless a last character waits as below. The scan state (phase,
// sign, magnitude, range flag) is updated in a single pass of the step logic.
// When rsp_ch stalls, the result waits in its output register and the
// block still takes the next characters of the following word; only a
// second last character then waits in the input register until the
// pending result is taken.
// Reset (synchronous, active high) empties both registers and returns the
// scan state to the start of a word.
`include "forth_token_literal_classifier_defines.svh"

module forth_token_literal_classifier (
   input logic       clock,
   input logic       reset,
   ftlc_req_if.sink  req_ch,
   ftlc_rsp_if.source rsp_ch
);

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic [7:0]           in_char_ff;
   logic                 in_last_ff;
   ftlc_pkg::state_type  state_ff;
   ftlc_pkg::state_type  state_in;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   ftlc_pkg::result_type out_result_ff;
   ftlc_pkg::result_type step_result;
   logic                 advance;
   logic                 req_fire;

   // Step logic between the input register and the result register.
   ftlc_step u_step (
      .cur_state  (state_ff),
      .char_code  (in_char_ff),
      .last_char  (in_last_ff),
      .next_state (state_in),
      .result     (step_result)
   );

   // A character leaves the input register unless it is a last character
   // facing a full output register that is not being drained.
   always_comb begin
      advance       = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ch.ready);
      req_ch.ready  = !in_valid_ff || advance;
      req_fire      = req_ch.valid && req_ch.ready;
      in_valid_in   = req_fire || (in_valid_ff && !advance);
      out_valid_in  = (advance && in_last_ff) || (out_valid_ff && !rsp_ch.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ftlc_pkg::STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_ch.char_code;
         in_last_ff <= req_ch.last_char;
      end
      if (advance && in_last_ff) begin
         out_result_ff <= step_result;
      end
   end

   // Result channel.
   always_comb begin
      rsp_ch.valid         = out_valid_ff;
      rsp_ch.word_kind     = out_result_ff.word_kind;
      rsp_ch.literal_value = out_result_ff.literal_value;
      rsp_ch.range_error   = out_result_ff.range_error;
   end

   `FTLC_ASSERT_SAME(a_other_is_blank, clock, reset,
      rsp_ch.valid && rsp_ch.word_kind == ftlc_pkg::KIND_OTHER,
      rsp_ch.literal_value == 32'sd0 && !rsp_ch.range_error,
      "other word carries a value or a range flag")
   `FTLC_ASSERT_SAME(a_range_zero_value, clock, reset,
      rsp_ch.valid && rsp_ch.range_error,
      rsp_ch.literal_value == 32'sd0,
      "range error with a nonzero value")
   `FTLC_ASSERT_NEXT(a_word_restart, clock, reset,
      advance && in_last_ff,
      state_ff.phase == ftlc_pkg::PH_START && state_ff.magnitude == '0 && !state_ff.overflowed,
      "scan state not restarted after the last character")
   `FTLC_ASSERT_NEXT(a_range_sticky, clock, reset,
      state_ff.overflowed && !(advance && in_last_ff),
      state_ff.overflowed,
      "range flag dropped inside a word")

endmodule
